[hw/rtl/uacs_pkg.sv]
// ----------------------------------------------------------------------------
// uacs_pkg
// Shared constants and byte classification helpers for the UTF-8 aware
// character sanitizer.
// ----------------------------------------------------------------------------
package uacs_pkg;

    // characters produced or recognized by the sanitizer
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BSLASH     = 8'h5c;
    localparam logic [7:0] CH_X          = 8'h78;

    // UTF-8 structure masks
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;

    // bytes that pass through unchanged
    function automatic logic keep_verbatim(input logic [7:0] b);
        logic keep;
        case (b) inside
            [8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a],
            8'h23, 8'h2b, 8'h2d, 8'h2e, 8'h3a, 8'h3d, 8'h40, 8'h5f,
            8'h2f, 8'h20, 8'h24, 8'h25, 8'h3f, 8'h2c: keep = 1'b1;
            default:                                  keep = 1'b0;
        endcase
        return keep;
    endfunction

    // sequence length announced by a lead byte, zero when not a lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // ascii whitespace other than space
    function automatic logic is_other_space(input logic [7:0] b);
        return (b >= 8'h09) && (b <= 8'h0d);
    endfunction

endpackage

[hw/rtl/utf8_aware_char_sanitizer.sv]
// ----------------------------------------------------------------------------
// utf8_aware_char_sanitizer
// Sanitizes a byte string: safe ASCII passes, backslash-x passes, complete
// UTF-8 sequences pass whole, other whitespace becomes a space and every
// other byte becomes an underscore.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-----------------------------------
//   input   | i_in_valid  | o_in_ready  | i_in_byte, i_in_last
//   output  | o_out_valid | i_out_ready | o_out_byte, o_run_last, o_string_end
//
// An input byte is taken into an input register, classified combinationally
// and its group of 0 to 4 result bytes loaded into a group register.
// The group register sends one byte per cycle while i_out_ready is high;
// the next input waits in the input register until the last byte of the
// current group is taken.
// Reset is synchronous and clears the hold state and both valid flags.
// Input is still accepted while the output side stalls, until the input
// register is also occupied.
// ----------------------------------------------------------------------------
module utf8_aware_char_sanitizer
    import uacs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_end
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // hold state
    logic [7:0] r_held [3];
    logic [1:0] r_held_cnt;
    logic [2:0] r_need_len;

    // result group register
    logic       r_grp_valid;
    logic [7:0] r_grp_byte [4];
    logic [2:0] r_grp_cnt;
    logic [1:0] r_grp_idx;
    logic       r_grp_last;

    logic       in_xfer;
    logic       out_xfer;
    logic       grp_free;
    logic       advance;

    // classification results
    logic       is_cont;
    logic [2:0] held_p1;
    logic       seq_done;
    logic       cont_hold;
    logic       fresh;
    logic       fresh_keep;
    logic       fresh_hold;
    logic       fresh_emit;
    logic [7:0] fresh_byte;
    logic [2:0] fresh_lead;
    logic [1:0] flush_cnt;
    logic [1:0] tail_cnt;
    logic [1:0] n_held_cnt;
    logic [2:0] n_need_len;
    logic [2:0] res_cnt;
    logic [7:0] res_byte [4];

    // handshakes
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_grp_valid && i_out_ready;
    assign o_out_valid = r_grp_valid;
    assign o_run_last  = (({1'b0, r_grp_idx} + 3'd1) == r_grp_cnt);
    assign o_string_end = o_run_last && r_grp_last;
    assign o_out_byte  = r_grp_byte[r_grp_idx];
    assign grp_free    = !r_grp_valid || (i_out_ready && o_run_last);
    assign advance     = r_in_valid && grp_free;
    assign o_in_ready  = !r_in_valid || grp_free;

    // decide the fate of the registered byte against the hold state
    always_comb begin
        is_cont    = ((r_in_byte & CONT_MASK) == CONT_CODE);
        held_p1    = {1'b0, r_held_cnt} + 3'd1;
        seq_done   = 1'b0;
        cont_hold  = 1'b0;
        fresh      = 1'b0;
        flush_cnt  = 2'd0;

        if (r_held_cnt == 2'd0) begin
            fresh = 1'b1;
        end else if (r_need_len == 3'd0) begin
            // held backslash
            if (r_in_byte == CH_X) begin
                seq_done = 1'b1;
            end else begin
                flush_cnt = r_held_cnt;
                fresh     = 1'b1;
            end
        end else if (is_cont) begin
            if (held_p1 == r_need_len) begin
                seq_done = 1'b1;
            end else begin
                cont_hold = 1'b1;
            end
        end else begin
            // broken sequence
            flush_cnt = r_held_cnt;
            fresh     = 1'b1;
        end

        // examine byte as if nothing were held
        fresh_keep = keep_verbatim(r_in_byte);
        fresh_lead = lead_length(r_in_byte);
        fresh_hold = fresh && !fresh_keep &&
                     ((r_in_byte == CH_BSLASH) || (fresh_lead != 3'd0));
        fresh_emit = fresh && !fresh_hold;
        if (fresh_keep) begin
            fresh_byte = r_in_byte;
        end else if (is_other_space(r_in_byte)) begin
            fresh_byte = CH_SPACE;
        end else begin
            fresh_byte = CH_UNDERSCORE;
        end

        // next hold state
        if (cont_hold) begin
            n_held_cnt = r_held_cnt + 2'd1;
            n_need_len = r_need_len;
        end else if (fresh_hold) begin
            n_held_cnt = 2'd1;
            n_need_len = fresh_lead;
        end else begin
            n_held_cnt = 2'd0;
            n_need_len = 3'd0;
        end

        // end of string flushes whatever is still held
        tail_cnt = 2'd0;
        if (r_in_last) begin
            tail_cnt   = n_held_cnt;
            n_held_cnt = 2'd0;
            n_need_len = 3'd0;
        end

        // result group
        if (seq_done) begin
            res_cnt     = held_p1;
            res_byte[0] = r_held[0];
            res_byte[1] = (r_held_cnt > 2'd1) ? r_held[1] : r_in_byte;
            res_byte[2] = (r_held_cnt > 2'd2) ? r_held[2] : r_in_byte;
            res_byte[3] = r_in_byte;
        end else begin
            res_cnt = {1'b0, flush_cnt} + {2'b00, fresh_emit} + {1'b0, tail_cnt};
            for (int j = 0; j < 4; j++) begin
                res_byte[j] = (fresh_emit && (2'(j) == flush_cnt)) ? fresh_byte
                                                                   : CH_UNDERSCORE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_held_cnt  <= 2'd0;
            r_need_len  <= 3'd0;
            r_grp_valid <= 1'b0;
            r_grp_cnt   <= 3'd0;
            r_grp_idx   <= 2'd0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            // a new group replaces the one whose last byte leaves now
            if (advance) begin
                r_held_cnt  <= n_held_cnt;
                r_need_len  <= n_need_len;
                r_grp_valid <= (res_cnt != 3'd0);
                r_grp_cnt   <= res_cnt;
                r_grp_idx   <= 2'd0;
            end else if (out_xfer) begin
                if (o_run_last) begin
                    r_grp_valid <= 1'b0;
                end
                r_grp_idx <= r_grp_idx + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (advance) begin
            r_grp_last <= r_in_last;
            for (int j = 0; j < 4; j++) begin
                r_grp_byte[j] <= res_byte[j];
            end
            if (cont_hold) begin
                r_held[r_held_cnt] <= r_in_byte;
            end else if (fresh_hold) begin
                r_held[0] <= r_in_byte;
            end
        end
    end

endmodule

[hw/rtl/uacs_checker.sv]
// ----------------------------------------------------------------------------
// uacs_checker
// Port-level checks for the UTF-8 aware character sanitizer, attached to
// the top level by bind.
// ----------------------------------------------------------------------------
module uacs_checker
    import uacs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_in_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_string_end
);

    // output transfer, once offered, is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_out_byte) && $stable(o_run_last)))
        else $error("output valid dropped before transfer");

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
        (i_in_valid && $stable(i_in_byte) && $stable(i_in_last)))
        else $error("input payload changed before transfer");

    // end of string only on the last byte of a run
    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_end) |-> o_run_last)
        else $error("string end outside run end");

    // with no result pending the input side is always open
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no pending result");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_aware_char_sanitizer uacs_checker u_uacs_checker (.*);
